// File: sv/tank_steer_to_goal_pid_defines.svh
// assertion macros for the go-to-goal steering block
`ifndef TANK_STEER_TO_GOAL_PID_DEFINES_SVH
`define TANK_STEER_TO_GOAL_PID_DEFINES_SVH
// concurrent check of a property on clk, off during reset
`define TSG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication that must hold on the following edge
`define TSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/tsg_pkg.sv
// ----------------------------------------------------------------------------
// tsg_pkg
// types and constants shared by the steering controller modules
// ----------------------------------------------------------------------------
package tsg_pkg;
	localparam logic signed [17:0] PI_Q     = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;
	localparam logic signed [16:0] SPEED_ONE = 17'sd16384;
	localparam logic [19:0] MICRO = 20'd1000000;
	// one million over 64
	localparam logic [13:0] MICRO_64 = 14'd15625;
	// floor of 2^45 / 15625
	localparam logic [31:0] RECIP_Q45 = 32'd2251799813;

	typedef enum logic [1:0] {MODE_IDLE = 2'd0, MODE_ORIENT = 2'd1, MODE_DRIVE = 2'd2,
		MODE_GOAL = 2'd3} mode_t;
	typedef enum logic [1:0] {ACT_NONE = 2'd0, ACT_SET = 2'd1, ACT_STOP = 2'd2} action_t;
	typedef enum logic [2:0] {REG_KP = 3'd0, REG_KI = 3'd1, REG_KD = 3'd2, REG_DTOL = 3'd3,
		REG_ATOL = 3'd4, REG_TURN = 3'd5, REG_CRUISE = 3'd6} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CORDIC, ST_DIST0, ST_DIST1, ST_DIST2, ST_DECIDE,
		ST_P1, ST_P2, ST_R1, ST_R2, ST_R3, ST_P3, ST_P4, ST_P5, ST_P6, ST_DIV, ST_P7, ST_P8,
		ST_OUT
	} state_t;

	// divider request/response
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

	function automatic logic signed [17:0] atan_lut(input logic [4:0] i);
		case (i)
			5'd0: atan_lut = 18'sd6434;
			5'd1: atan_lut = 18'sd3798;
			5'd2: atan_lut = 18'sd2007;
			5'd3: atan_lut = 18'sd1019;
			5'd4: atan_lut = 18'sd511;
			5'd5: atan_lut = 18'sd256;
			5'd6: atan_lut = 18'sd128;
			5'd7: atan_lut = 18'sd64;
			5'd8: atan_lut = 18'sd32;
			5'd9: atan_lut = 18'sd16;
			5'd10: atan_lut = 18'sd8;
			5'd11: atan_lut = 18'sd4;
			5'd12: atan_lut = 18'sd2;
			5'd13: atan_lut = 18'sd1;
			default: atan_lut = 18'sd0;
		endcase
	endfunction
endpackage

// File: sv/tank_steer_to_goal_pid.sv
// ----------------------------------------------------------------------------
// tank_steer_to_goal_pid
// go-to-goal steering controller for a two-wheeled robot
// ----------------------------------------------------------------------------
// One item at a time. A start transfer goes to the output state and presents
// its result on the following edge. A pose update runs a shared shift-add
// CORDIC stage (preceded by a rotation by pi when the goal lies at negative x
// offset), the distance check on a single shared 33x33 multiplier and a
// decision state. In drive mode the PID law follows, waiting on a bit-serial
// divider for the derivative term. The result waits in an output register;
// s_tready is low while busy and while a result waits.
module tank_steer_to_goal_pid import tsg_pkg::*; #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [143:0] s_tdata, // goal_x, goal_y, pose_x, pose_y, pose_yaw, time_us
	input  logic        s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // motor_action, left_speed, right_speed, mode, at_goal
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	`include "tank_steer_to_goal_pid_defines.svh"

	localparam int CW = $clog2(CORDIC_STEPS + 1);

	logic signed [23:0] kp_q, ki_q, kd_q;
	logic [22:0] dtol_q;
	logic [14:0] atol_q, turn_q, cruise_q;
	mode_t mode_q;
	logic signed [23:0] tx_q, ty_q;
	logic signed [15:0] prev_q;
	logic [31:0] lap_q;

	state_t st_q, st_d;
	logic signed [15:0] yaw_q;
	logic [31:0] now_q;

	// cordic registers
	logic signed [42:0] cx_q, cy_q;
	logic signed [17:0] cz_q;
	logic [CW-1:0] ci_q;
	logic signed [24:0] dx_q, dy_q;

	// shared multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] mprod;
	logic signed [65:0] mr_q;
	logic [63:0] acc_q;
	logic signed [17:0] e_q;
	logic [31:0] dt_q;
	logic signed [63:0] sum_q;
	logic signed [27:0] inner_q;
	logic div_neg_q;

	// rounded division by one million
	logic [41:0] nq_q;
	logic [27:0] q0_q;
	logic [16:0] r_q;
	logic [27:0] qfix;

	div_req_t dreq;
	div_rsp_t drsp;

	logic [1:0] act_q;
	logic signed [15:0] ls_q, rs_q;
	logic ovalid_q;

	tsg_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_tready = (st_q == ST_IDLE) && !ovalid_q;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {3'b000, mode_q == MODE_GOAL, mode_q, rs_q, ls_q, act_q};

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= 24'sd65536; ki_q <= '0; kd_q <= '0;
			dtol_q <= 23'd102; atol_q <= 15'd819; turn_q <= 15'd4096;
			cruise_q <= 15'd8192;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KP:     kp_q <= cfg_data;
				REG_KI:     ki_q <= cfg_data;
				REG_KD:     kd_q <= cfg_data;
				REG_DTOL:   dtol_q <= cfg_data[22:0];
				REG_ATOL:   atol_q <= cfg_data[14:0];
				REG_TURN:   turn_q <= cfg_data[14:0];
				REG_CRUISE: cruise_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// angle error and helpers
	logic signed [18:0] raw_e, wrapped;
	logic signed [17:0] mag_e;
	logic near_goal;
	always_comb begin
		raw_e = {cz_q[17], cz_q} - 19'(yaw_q);
		wrapped = raw_e;
		if (raw_e > 19'(PI_Q)) wrapped = raw_e - 19'(TWO_PI_Q);
		else if (raw_e < -19'(PI_Q)) wrapped = raw_e + 19'(TWO_PI_Q);
		mag_e = e_q[17] ? -e_q : e_q;
		near_goal = acc_q < mr_q[63:0];
	end

	// multiplier operand select
	always_comb begin
		ma = '0; mb = '0;
		unique case (st_q)
			ST_DIST0: begin ma = 33'(dx_q); mb = 33'(dx_q); end
			ST_DIST1: begin ma = 33'(dy_q); mb = 33'(dy_q); end
			ST_DIST2: begin ma = {10'd0, dtol_q}; mb = {10'd0, dtol_q}; end
			ST_P1: begin ma = 33'(prev_q); mb = {1'b0, dt_q}; end
			ST_R1: begin ma = {5'd0, nq_q[41:14]}; mb = {1'b0, RECIP_Q45}; end
			ST_R2: begin ma = {5'd0, q0_q}; mb = 33'(MICRO_64); end
			ST_P3: begin ma = 33'(kp_q); mb = 33'(e_q); end
			ST_P4: begin ma = 33'(ki_q); mb = 33'(inner_q); end
			ST_P5: begin ma = 33'(prev_q) - 33'(e_q); mb = 33'(MICRO_64); end
			ST_P6: begin ma = mr_q[32:0]; mb = 33'(kd_q); end
			default: ;
		endcase
		mprod = ma * mb;
	end

	// quotient estimate is low by at most two
	always_comb begin
		qfix = q0_q + ((r_q >= 17'(2 * MICRO_64)) ? 28'd2 :
			(r_q >= 17'(MICRO_64)) ? 28'd1 : 28'd0);
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (s_tvalid && s_tready) st_d = s_tuser ? ST_CORDIC : ST_OUT;
			ST_CORDIC: if (ci_q == CW'(CORDIC_STEPS)) st_d = ST_DIST0;
			ST_DIST0: st_d = ST_DIST1;
			ST_DIST1: st_d = ST_DIST2;
			ST_DIST2: st_d = ST_DECIDE;
			ST_DECIDE: st_d = (!near_goal && mode_q == MODE_DRIVE
				&& !(mag_e > 18'(turn_q))) ? ST_P1 : ST_OUT;
			ST_P1: st_d = ST_P2;
			ST_P2: st_d = ST_R1;
			ST_R1: st_d = ST_R2;
			ST_R2: st_d = ST_R3;
			ST_R3: st_d = ST_P3;
			ST_P3: st_d = ST_P4;
			ST_P4: st_d = ST_P5;
			ST_P5: st_d = ST_P6;
			ST_P6: st_d = ST_DIV;
			ST_DIV: if (drsp.done) st_d = ST_P7;
			ST_P7: st_d = ST_P8;
			ST_P8: st_d = ST_OUT;
			ST_OUT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// divider control
	logic [63:0] dmag;
	always_comb begin
		dreq = '0;
		unique case (st_q)
			ST_P6: begin
				dmag = (mprod[65] ? 64'(-mprod) : mprod[63:0]) << 6;
				dreq.start = 1'b1;
				dreq.num = dmag + 64'(dt_q >> 1);
				dreq.den = dt_q;
			end
			default: dmag = '0;
		endcase
	end

	logic signed [63:0] qsig, sumf;
	logic signed [49:0] dfr, df_mag;
	logic signed [50:0] v1, v2;
	logic signed [16:0] c1, c2;
	always_comb begin
		qsig = div_neg_q ? -$signed(drsp.quo) : $signed(drsp.quo);
		sumf = sum_q;
		df_mag = sumf[63] ? 50'((-sumf + 64'sd16384) >>> 15) : 50'((sumf + 64'sd16384) >>> 15);
		dfr = sumf[63] ? -df_mag : df_mag;
		v1 = 51'(cruise_q) + 51'(dfr);
		v2 = 51'(cruise_q) - 51'(dfr);
		c1 = v1 < 0 ? 17'sd0 : (v1 > 51'(SPEED_ONE) ? SPEED_ONE : 17'(v1));
		c2 = v2 < 0 ? 17'sd0 : (v2 > 51'(SPEED_ONE) ? SPEED_ONE : 17'(v2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			mode_q <= MODE_IDLE;
			tx_q <= '0; ty_q <= '0; prev_q <= '0; lap_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ovalid_q && m_tready) ovalid_q <= 1'b0;
			if (st_q == ST_OUT) ovalid_q <= 1'b1;
			if (st_q == ST_IDLE && s_tvalid && s_tready && !s_tuser) begin
				tx_q <= s_tdata[23:0];
				ty_q <= s_tdata[47:24];
				mode_q <= MODE_ORIENT;
			end
			if (st_q == ST_DECIDE) begin
				if (near_goal) mode_q <= MODE_GOAL;
				else if (mode_q == MODE_ORIENT && !(mag_e > 18'(atol_q))) begin
					mode_q <= MODE_DRIVE;
					lap_q <= now_q;
					prev_q <= 16'(e_q);
				end else if (mode_q == MODE_DRIVE && mag_e > 18'(turn_q))
					mode_q <= MODE_ORIENT;
			end
			if (st_q == ST_P1) lap_q <= now_q;
			if (st_q == ST_P8) prev_q <= 16'(e_q);
		end
	end

	logic moving;
	assign moving = mode_q == MODE_ORIENT || mode_q == MODE_DRIVE;

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (s_tvalid && s_tready) begin
				yaw_q <= s_tdata[111:96];
				now_q <= s_tdata[143:112];
				act_q <= (!s_tuser && moving) ? ACT_STOP : ACT_NONE;
				ls_q <= '0; rs_q <= '0;
				dx_q <= 25'(tx_q) - 25'($signed(s_tdata[71:48]));
				dy_q <= 25'(ty_q) - 25'($signed(s_tdata[95:72]));
				ci_q <= '0;
				cz_q <= '0;
				cx_q <= 43'(25'(tx_q) - 25'($signed(s_tdata[71:48]))) <<< 16;
				cy_q <= 43'(25'(ty_q) - 25'($signed(s_tdata[95:72]))) <<< 16;
			end
			ST_CORDIC: begin
				if (ci_q == '0 && cx_q < 0) begin
					cx_q <= -cx_q; cy_q <= -cy_q;
					cz_q <= (dy_q >= 0) ? PI_Q : -PI_Q;
				end else if (ci_q == CW'(CORDIC_STEPS)) begin
					if (dx_q == 0 && dy_q == 0) cz_q <= '0;
				end else begin
					if (cy_q > 0) begin
						cx_q <= cx_q + (cy_q >>> ci_q);
						cy_q <= cy_q - (cx_q >>> ci_q);
						cz_q <= cz_q + atan_lut(5'(ci_q));
					end else begin
						cx_q <= cx_q - (cy_q >>> ci_q);
						cy_q <= cy_q + (cx_q >>> ci_q);
						cz_q <= cz_q - atan_lut(5'(ci_q));
					end
					ci_q <= ci_q + CW'(1);
				end
				if (ci_q == '0 && cx_q < 0) ci_q <= '0;
			end
			ST_DIST0: begin mr_q <= mprod; e_q <= 18'(wrapped);
				dt_q <= (now_q - lap_q == 0) ? 32'd1 : now_q - lap_q; end
			ST_DIST1: acc_q <= mr_q[63:0] + mprod[63:0];
			ST_DIST2: mr_q <= mprod;
			ST_DECIDE: begin
				if (near_goal) act_q <= moving ? ACT_STOP : ACT_NONE;
				else if (mode_q == MODE_ORIENT) begin
					if (!(mag_e > 18'(atol_q))) act_q <= ACT_STOP;
					else begin
						act_q <= ACT_SET;
						ls_q <= e_q[17] ? 16'(SPEED_ONE) : -16'(SPEED_ONE);
						rs_q <= e_q[17] ? -16'(SPEED_ONE) : 16'(SPEED_ONE);
					end
				end else if (mode_q == MODE_DRIVE && mag_e > 18'(turn_q))
					act_q <= ACT_STOP;
			end
			ST_P1: mr_q <= mprod;
			ST_P2: begin
				div_neg_q <= mr_q[65];
				nq_q <= 42'(((mr_q[65] ? 64'(-mr_q) : mr_q[63:0]) + 64'(MICRO >> 1)) >> 6);
			end
			ST_R1: q0_q <= mprod[58:31];
			ST_R2: r_q <= nq_q[16:0] - mprod[16:0];
			ST_R3: inner_q <= 28'(e_q) + (div_neg_q ? -$signed(qfix) : $signed(qfix));
			ST_P3: sum_q <= 64'(mprod);
			ST_P4: sum_q <= sum_q + 64'(mprod);
			ST_P5: mr_q <= mprod;
			ST_P6: div_neg_q <= mprod[65];
			ST_P7: sum_q <= sum_q + qsig;
			ST_P8: begin
				act_q <= ACT_SET;
				ls_q <= sum_q[63] ? 16'(c2) : 16'(c1);
				rs_q <= sum_q[63] ? 16'(c1) : 16'(c2);
			end
			default: ;
		endcase
	end

	`TSG_ASSERT(a_ready_idle, !(s_tready && st_q != ST_IDLE), "ready while busy")
	`TSG_ASSERT_NEXT(a_out_valid, st_q == ST_OUT, m_tvalid, "result not presented")
	`TSG_ASSERT(a_goal_flag, !(m_tvalid && m_tdata[36] != (m_tdata[35:34] == MODE_GOAL)),
		"at_goal mismatch")
	`TSG_ASSERT(a_div_idle, !(drsp.busy && st_q != ST_DIV), "divider busy outside wait")
endmodule

// File: sv/tsg_div.sv
// ----------------------------------------------------------------------------
// tsg_div
// radix-2 restoring divider, one quotient bit per cycle, unsigned 64 by 32
// ----------------------------------------------------------------------------
module tsg_div import tsg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
